// ----- hw/rtl/peq_pkg.sv -----
// Shared types and codes for the priority expiring packet queue.
`default_nettype none
package peq_pkg;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_EXPIRY = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  level;
        logic [15:0] data_length;
        logic [31:0] payload_handle;
        logic [31:0] tag;
        logic [15:0] buffer_size;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  packet_count;
        logic [7:0]  level_out;
        logic [31:0] tag_out;
        logic [15:0] length_out;
        logic [31:0] payload_out;
        logic [6:0]  discarded_count;
        logic        queue_empty;
    } out_word_t;

    // One queue entry as held in a cell.
    typedef struct packed {
        logic [7:0]  level;
        logic [31:0] tag;
        logic [15:0] length;
        logic [31:0] payload;
        logic [31:0] push_time;
    } entry_t;

    // Row-wide command from the controller to every cell.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] level;
        logic       to_head;
    } cell_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/peq_cell.sv -----
// One queue cell: holds one entry, shifts toward the head on insert and the tail on pop.
`default_nettype none
module peq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire peq_pkg::cell_cmd_t cmd,
    input  wire peq_pkg::entry_t    new_entry,
    // neighbor toward the tail (lower position)
    input  wire logic               prev_occ,
    input  wire peq_pkg::entry_t    prev_entry,
    input  wire logic               lower_in,
    // neighbor toward the head (higher position)
    input  wire logic               next_occ,
    input  wire peq_pkg::entry_t    next_entry,
    output logic                    occ,
    output peq_pkg::entry_t         entry,
    output logic                    lower_out
);

    logic            occ_reg, occ_next;
    peq_pkg::entry_t entry_reg, entry_next;
    logic            lower_self;

    // an entry of strictly lower level marks the insert point; the first one
    // from the tail side takes the new entry, all cells above it shift up
    assign lower_self = occ_reg && !cmd.to_head && (entry_reg.level < cmd.level);
    assign lower_out  = lower_in || lower_self;

    // next state: shift up on insert, load the new entry, or shift down on pop
    always_comb
    begin
        occ_next   = occ_reg;
        entry_next = entry_reg;
        if (cmd.push)
        begin
            if (lower_in)
            begin
                occ_next   = prev_occ;
                entry_next = prev_entry;
            end
            else if (lower_self || (!occ_reg && prev_occ))
            begin
                occ_next   = 1'b1;
                entry_next = new_entry;
            end
        end
        else if (cmd.pop)
        begin
            occ_next   = next_occ;
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    // entry contents need no reset; unoccupied cells are never read
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign occ   = occ_reg;
    assign entry = entry_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/priority_expiring_packet_queue.sv -----
// Top level: controller and row of queue cells.
// A push, tick or unused request goes from S_IDLE through S_DONE and back to
// S_IDLE before the next acceptance, a push result being registered as S_DONE
// is left; a pop stays in S_POP while entries are discarded, the tail cell
// (cell 0) being examined and removed one entry a cycle. Sorted insert is done
// at once by the row of cells, each cell deciding locally whether to hold, take
// its neighbor's entry, or load the new entry. One item is in work at a time;
// the input is stalled while a finished result waits under a stalled receiver.
`default_nettype none
module priority_expiring_packet_queue #(
    parameter int ENTRIES        = 64,
    parameter int ENTRY_OVERHEAD = 40,
    parameter int HEADROOM       = 200
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire peq_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output peq_pkg::out_word_t     out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data
);

    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_POP, S_DONE} state_t;

    state_t            state_reg;
    peq_pkg::in_word_t req_reg;
    logic [31:0]       budget_reg, expiry_reg, ms_reg;
    logic [32:0]       used_reg;
    logic [CW-1:0]     count_reg;
    logic [6:0]        disc_reg;
    logic              ov_reg;
    peq_pkg::out_word_t ow_reg;

    // cell row links: cell g drives index g+1, index 0 and the top are ends
    logic [ENTRIES+1:0] occ_x;
    logic [ENTRIES:0]   lower_x;
    peq_pkg::entry_t    ent_x [ENTRIES+2];

    assign occ_x[0]         = 1'b1;
    assign occ_x[ENTRIES+1] = 1'b0;
    assign ent_x[0]         = '0;
    assign ent_x[ENTRIES+1] = '0;
    assign lower_x[0]       = 1'b0;

    // tail entry sits in cell 0
    peq_pkg::entry_t tail_e;
    assign tail_e = ent_x[1];

    logic [34:0] need;
    logic        full;
    assign need = {2'b0, used_reg} + 35'(req_reg.data_length)
                + 35'(ENTRY_OVERHEAD + HEADROOM);
    assign full = (need > {3'b0, budget_reg}) || (count_reg == CW'(ENTRIES));

    logic [32:0] cost;
    logic [31:0] age;
    logic        drop;
    assign cost = 33'(tail_e.length) + 33'(ENTRY_OVERHEAD);
    assign age  = ms_reg - tail_e.push_time;
    assign drop = (age >= expiry_reg) || (tail_e.length > req_reg.buffer_size);

    peq_pkg::entry_t ne;
    assign ne = '{level: req_reg.level, tag: req_reg.tag, length: req_reg.data_length,
                  payload: req_reg.payload_handle, push_time: ms_reg};

    logic in_acc, out_acc;
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = ov_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign out_data  = ow_reg;

    function automatic peq_pkg::out_word_t mk(logic [1:0] st, logic [CW-1:0] c,
                                              peq_pkg::entry_t e, logic [6:0] d);
        peq_pkg::out_word_t o;
        o.status = st;
        o.packet_count = 7'(c);
        o.level_out = e.level;
        o.tag_out = e.tag;
        o.length_out = e.length;
        o.payload_out = e.payload;
        o.discarded_count = d;
        o.queue_empty = (c == '0);
        return o;
    endfunction

    // row-wide command
    peq_pkg::cell_cmd_t cmd;
    always_comb
    begin
        cmd.push    = (state_reg == S_DONE) && (req_reg.req_type == peq_pkg::REQ_PUSH)
                    && !full;
        cmd.pop     = (state_reg == S_POP) && (count_reg != '0);
        cmd.level   = req_reg.level;
        cmd.to_head = (req_reg.level == 8'd1);
    end

    // control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            req_reg    <= '0;
            budget_reg <= 32'd1048576;
            expiry_reg <= 32'd1000;
            ms_reg     <= '0;
            used_reg   <= '0;
            count_reg  <= '0;
            disc_reg   <= '0;
            ov_reg     <= 1'b0;
            ow_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == peq_pkg::CFG_BUDGET) budget_reg <= cfg_data;
                else expiry_reg <= cfg_data;
            end
            if (out_acc)
                ov_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_acc)
                    begin
                        req_reg   <= in_data;
                        disc_reg  <= '0;
                        state_reg <= (in_data.req_type == peq_pkg::REQ_POP) ? S_POP : S_DONE;
                    end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    if (req_reg.req_type == peq_pkg::REQ_TICK)
                        ms_reg <= ms_reg + 32'd1;
                    else if (req_reg.req_type == peq_pkg::REQ_PUSH)
                    begin
                        ov_reg <= 1'b1;
                        if (full)
                            ow_reg <= mk(peq_pkg::ST_FULL, count_reg, '0, '0);
                        else
                        begin
                            count_reg <= count_reg + CW'(1);
                            used_reg  <= used_reg + 33'(req_reg.data_length)
                                       + 33'(ENTRY_OVERHEAD);
                            ow_reg <= mk(peq_pkg::ST_OK, count_reg + CW'(1), '0, '0);
                        end
                    end
                end
                S_POP:
                    if (count_reg == '0)
                    begin
                        ov_reg    <= 1'b1;
                        ow_reg    <= mk(peq_pkg::ST_EMPTY, count_reg, '0, disc_reg);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        count_reg <= count_reg - CW'(1);
                        used_reg  <= (used_reg > cost) ? used_reg - cost : '0;
                        if (drop)
                            disc_reg <= disc_reg + 7'd1;
                        else
                        begin
                            ov_reg    <= 1'b1;
                            ow_reg    <= mk(peq_pkg::ST_OK, count_reg - CW'(1), tail_e,
                                            disc_reg);
                            state_reg <= S_IDLE;
                        end
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // cell row: cell 0 is the tail, higher cells lie toward the head
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        peq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .new_entry (ne),
            .prev_occ  (occ_x[g]),
            .prev_entry(ent_x[g]),
            .lower_in  (lower_x[g]),
            .next_occ  (occ_x[g+2]),
            .next_entry(ent_x[g+2]),
            .occ       (occ_x[g+1]),
            .entry     (ent_x[g+1]),
            .lower_out (lower_x[g+1])
        );
    end

endmodule
`default_nettype wire

// ----- hw/rtl/peq_checker.sv -----
// Port-level checker for the priority expiring packet queue.
`default_nettype none
module peq_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire peq_pkg::out_word_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.queue_empty == (out_data.packet_count == 7'd0))
        else $error("empty flag");
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == peq_pkg::ST_FULL |-> out_data.discarded_count == 7'd0)
        else $error("full push discards");
    // one word in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall) else $error("busy accept");
    // a waiting result holds the input off
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall) else $error("back pressure");
endmodule

bind priority_expiring_packet_queue peq_checker u_peq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ----- test/priority_expiring_packet_queue_test.sv -----
// Testbench for the priority expiring packet queue, checked against a predictor.
`timescale 1ns / 1ps
module priority_expiring_packet_queue_test;

    localparam int ENTRIES  = 64;
    localparam int OVERHEAD = 40;
    localparam int HEADROOM = 200;
    localparam int HOLD_LEN = 400;
    // request code with no meaning; the block ignores it
    localparam logic [1:0] REQ_NONE = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    peq_pkg::in_word_t in_data;
    logic out_valid;
    logic out_stall;
    peq_pkg::out_word_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [31:0] cfg_data;

    priority_expiring_packet_queue dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state
    peq_pkg::entry_t q_slots[ENTRIES];
    int unsigned     q_count = 0;
    logic [32:0]     q_used = '0;
    logic [31:0]     q_clock = '0;
    logic [31:0]     q_budget = 32'd1048576;
    logic [31:0]     q_expiry = 32'd1000;

    peq_pkg::in_word_t  pending_words[$];
    peq_pkg::out_word_t expected_results[$];
    int unsigned errors = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_req;
    int unsigned hold_seen;
    int unsigned hold_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic peq_pkg::out_word_t queue_result(logic [1:0] st, peq_pkg::entry_t e,
                                                        int unsigned disc);
        peq_pkg::out_word_t r;
        r.status          = st;
        r.packet_count    = q_count[6:0];
        r.level_out       = e.level;
        r.tag_out         = e.tag;
        r.length_out      = e.length;
        r.payload_out     = e.payload;
        r.discarded_count = disc[6:0];
        r.queue_empty     = (q_count == 0);
        return r;
    endfunction

    // Advance predictor by one word; push the expected result if any
    task automatic predict_queue(peq_pkg::in_word_t w);
        peq_pkg::entry_t e;
        peq_pkg::entry_t z;
        logic [33:0]     need;
        logic [32:0]     cost;
        int unsigned     pos;
        int unsigned     disc;
        logic [31:0]     age;
        z = '0;
        disc = 0;
        pos = 0;
        case (w.req_type)
            peq_pkg::REQ_PUSH:
            begin
                need = {1'b0, q_used} + 34'(w.data_length) + 34'(OVERHEAD + HEADROOM);
                if (need > {2'b0, q_budget} || q_count >= ENTRIES)
                    expected_results.push_back(queue_result(peq_pkg::ST_FULL, z, 0));
                else
                begin
                    if (w.level != 8'd1)
                        for (int i = int'(q_count); i > 0; i--)
                            if (q_slots[i-1].level < w.level)
                            begin
                                pos = unsigned'(i);
                                break;
                            end
                    for (int i = int'(q_count); i > int'(pos); i--)
                        q_slots[i] = q_slots[i-1];
                    e.level = w.level;
                    e.tag = w.tag;
                    e.length = w.data_length;
                    e.payload = w.payload_handle;
                    e.push_time = q_clock;
                    q_slots[pos] = e;
                    q_count++;
                    q_used = q_used + 33'(w.data_length) + 33'(OVERHEAD);
                    expected_results.push_back(queue_result(peq_pkg::ST_OK, z, 0));
                end
            end
            peq_pkg::REQ_POP:
            begin
                while (q_count > 0)
                begin
                    e = q_slots[q_count-1];
                    cost = 33'(e.length) + 33'(OVERHEAD);
                    age = q_clock - e.push_time;
                    q_count--;
                    q_used = (q_used > cost) ? q_used - cost : '0;
                    if (age >= q_expiry || e.length > w.buffer_size)
                        disc++;
                    else
                    begin
                        expected_results.push_back(queue_result(peq_pkg::ST_OK, e, disc));
                        return;
                    end
                end
                expected_results.push_back(queue_result(peq_pkg::ST_EMPTY, z, disc));
            end
            peq_pkg::REQ_TICK: q_clock = q_clock + 32'd1;
            default: ;
        endcase
    endtask

    function automatic peq_pkg::in_word_t make_word(logic [1:0] rt, logic [7:0] lv,
                                                    logic [15:0] len, logic [15:0] buf_sz);
        peq_pkg::in_word_t w;
        w.req_type       = rt;
        w.level          = lv;
        w.data_length    = len;
        w.payload_handle = $urandom;
        w.tag            = $urandom;
        w.buffer_size    = buf_sz;
        return w;
    endfunction

    function automatic peq_pkg::in_word_t random_word();
        int unsigned r;
        peq_pkg::in_word_t w;
        r = $urandom_range(99);
        w = make_word(peq_pkg::REQ_PUSH, 8'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(3) != 0)
            w.level = 8'($urandom_range(4));
        if ($urandom_range(3) != 0)
            w.data_length = 16'($urandom_range(1500));
        if ($urandom_range(3) != 0)
            w.buffer_size = 16'hffff - 16'($urandom_range(200));
        if (r < 50)
            w.req_type = peq_pkg::REQ_PUSH;
        else if (r < 85)
            w.req_type = peq_pkg::REQ_POP;
        else if (r < 98)
            w.req_type = peq_pkg::REQ_TICK;
        else
            w.req_type = REQ_NONE;
        return w;
    endfunction

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_words.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Predict on acceptance
    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            predict_queue(in_data);

    // Receiver stall, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            hold_seen  <= 0;
            hold_count <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen  <= hold_req;
            hold_count <= HOLD_LEN;
            out_stall  <= 1'b1;
        end
        else if (hold_count != 0)
        begin
            hold_count <= hold_count - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor
    always @(posedge clk)
    begin
        peq_pkg::out_word_t x;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                errors++;
            end
            else
            begin
                x = expected_results.pop_front();
                if (out_data.status !== x.status || out_data.packet_count !== x.packet_count
                    || out_data.level_out !== x.level_out || out_data.tag_out !== x.tag_out
                    || out_data.length_out !== x.length_out
                    || out_data.payload_out !== x.payload_out
                    || out_data.discarded_count !== x.discarded_count
                    || out_data.queue_empty !== x.queue_empty)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, x, out_data);
                    errors++;
                end
            end
        end
    end

    task automatic drain_all();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == peq_pkg::CFG_BUDGET)
            q_budget = val;
        else
            q_expiry = val;
        @(posedge clk);
    endtask

    task automatic random_phase(int unsigned n);
        for (int i = 0; i < n; i++)
            pending_words.push_back(random_word());
        drain_all();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = peq_pkg::CFG_BUDGET;
        cfg_data = '0;
        send_idle_pct = 8;
        recv_idle_pct = 55;
        hold_req = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, level 1 to head, ordering, oversize, ignored code
        pending_words.push_back(make_word(peq_pkg::REQ_POP, 8'd0, 16'd0, 16'hffff));
        pending_words.push_back(make_word(peq_pkg::REQ_PUSH, 8'd3, 16'd10, 16'd0));
        pending_words.push_back(make_word(peq_pkg::REQ_PUSH, 8'd1, 16'd20, 16'd0));
        pending_words.push_back(make_word(peq_pkg::REQ_PUSH, 8'd255, 16'hffff, 16'd0));
        pending_words.push_back(make_word(peq_pkg::REQ_PUSH, 8'd0, 16'd0, 16'd0));
        pending_words.push_back(make_word(peq_pkg::REQ_PUSH, 8'd3, 16'd5, 16'd0));
        pending_words.push_back(make_word(peq_pkg::REQ_POP, 8'd0, 16'd0, 16'd100));
        pending_words.push_back(make_word(peq_pkg::REQ_POP, 8'd0, 16'd0, 16'hffff));
        pending_words.push_back(make_word(REQ_NONE, 8'hff, 16'hffff, 16'hffff));
        pending_words.push_back(make_word(peq_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0));
        pending_words.push_back(make_word(peq_pkg::REQ_POP, 8'd0, 16'd0, 16'hffff));
        pending_words.push_back(make_word(peq_pkg::REQ_POP, 8'd0, 16'd0, 16'hffff));
        pending_words.push_back(make_word(peq_pkg::REQ_POP, 8'd0, 16'd0, 16'hffff));
        drain_all();

        // Zero expiry drops everything; tiny budget refuses all but the first push
        write_reg(peq_pkg::CFG_EXPIRY, 32'd0);
        write_reg(peq_pkg::CFG_BUDGET, 32'd300);
        pending_words.push_back(make_word(peq_pkg::REQ_PUSH, 8'd2, 16'd60, 16'd0));
        pending_words.push_back(make_word(peq_pkg::REQ_PUSH, 8'd2, 16'd61, 16'd0));
        pending_words.push_back(make_word(peq_pkg::REQ_PUSH, 8'd2, 16'd0, 16'd0));
        pending_words.push_back(make_word(peq_pkg::REQ_POP, 8'd0, 16'd0, 16'hffff));
        drain_all();

        // Long receiver hold-off while pushes fill the queue
        write_reg(peq_pkg::CFG_BUDGET, 32'hffffffff);
        write_reg(peq_pkg::CFG_EXPIRY, 32'hffffffff);
        for (int i = 0; i < 70; i++)
            pending_words.push_back(make_word(peq_pkg::REQ_PUSH, 8'($urandom_range(5)),
                                              16'($urandom), 16'd0));
        hold_req++;
        drain_all();
        random_phase(300);

        // Short expiry with ticks; the phase ends once all results are in
        write_reg(peq_pkg::CFG_EXPIRY, 32'd5);
        write_reg(peq_pkg::CFG_BUDGET, 32'd20000);
        random_phase(400);

        // Swap idle rates
        send_idle_pct = 55;
        recv_idle_pct = 8;
        write_reg(peq_pkg::CFG_BUDGET, 32'd1048576);
        write_reg(peq_pkg::CFG_EXPIRY, 32'd40);
        random_phase(500);

        // No idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(peq_pkg::CFG_BUDGET, 32'd0);
        random_phase(50);
        write_reg(peq_pkg::CFG_BUDGET, 32'd200000);
        write_reg(peq_pkg::CFG_EXPIRY, 32'd1000);
        random_phase(550);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/peq_pkg.sv
hw/rtl/peq_cell.sv
hw/rtl/priority_expiring_packet_queue.sv
hw/rtl/peq_checker.sv
test/priority_expiring_packet_queue_test.sv
